// ----- hw/rtl/losv_pkg.sv -----
// Package for the line-of-sight visibility unit: transaction payload types,
// map access structs, register indexes and fixed widths.
// Used by every module of the block; depends on nothing.
package losv_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int COORD_W     = 7;
   localparam int RAD_W       = 30;
   localparam int ROOT_W      = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_FALLOFF_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALLOFF_SLOPE  = 1'b1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [9:0] OFFSET_RESET = 10'd512;
   localparam logic [7:0] SLOPE_RESET  = 8'd77;

   typedef struct packed {
      logic       command;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic       cell_free;
      logic [9:0] viewer_x;
      logic [9:0] viewer_y;
   } req_payload_type;

   typedef struct packed {
      logic [8:0] visibility;
      logic       blocked;
   } rsp_payload_type;

   typedef struct packed {
      logic               rd;
      logic               wr;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               free;
   } map_req_type;

   typedef struct packed {
      logic busy;
      logic blocked;
   } map_rsp_type;

endpackage

// ----- hw/rtl/losv_map.sv -----
// Occupancy map of the visibility unit: one synchronous memory of map rows,
// a clearing pass after reset and a read-modify-write path for cell writes.
// Depends on losv_pkg.
module losv_map #(
   parameter int MAP_WIDTH,
   parameter int MAP_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  losv_pkg::map_req_type req,
   output losv_pkg::map_rsp_type rsp
);
   import losv_pkg::*;

   localparam int COL_AW = $clog2(MAP_WIDTH);
   localparam int ROW_AW = $clog2(MAP_HEIGHT);
   localparam int EXT_W  = 11;

   logic [MAP_WIDTH-1:0] mem [MAP_HEIGHT];

   logic                 clr_ff,  clr_in;
   logic [ROW_AW-1:0]    clr_row_ff, clr_row_in;
   logic                 pend_ff, pend_in;
   logic                 hit_ff,  hit_in;
   logic [COL_AW-1:0]    col_ff;
   logic [ROW_AW-1:0]    row_ff;
   logic                 free_ff;
   logic [MAP_WIDTH-1:0] row_data_ff;

   logic [EXT_W-1:0]     col_ext, row_ext;
   logic                 col_ok, row_ok, mem_re, mem_we;
   logic [ROW_AW-1:0]    mem_waddr;
   logic [MAP_WIDTH-1:0] mem_wdata, wb_row;

   assign col_ext = {{(EXT_W-COORD_W){1'b0}}, req.col};
   assign row_ext = {{(EXT_W-COORD_W){1'b0}}, req.row};
   assign col_ok  = col_ext < EXT_W'(MAP_WIDTH);
   assign row_ok  = row_ext < EXT_W'(MAP_HEIGHT);
   assign mem_re  = (req.rd | req.wr) & col_ok & row_ok;
   assign hit_in  = mem_re;
   assign pend_in = req.wr;

   always_comb begin
      wb_row         = row_data_ff;
      wb_row[col_ff] = ~free_ff;
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_row_in = clr_row_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         if (clr_row_ff == ROW_AW'(MAP_HEIGHT - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = row_ff;
      mem_wdata = wb_row;
      if (clr_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_row_ff;
         mem_wdata = '0;
      end else if (pend_ff && hit_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_row_ff <= '0;
         pend_ff    <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         clr_row_ff <= clr_row_in;
         pend_ff    <= pend_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         col_ff  <= col_ext[COL_AW-1:0];
         row_ff  <= row_ext[ROW_AW-1:0];
         free_ff <= req.free;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         row_data_ff <= mem[row_ext[ROW_AW-1:0]];
      end
   end

   assign rsp.busy    = clr_ff | pend_ff;
   assign rsp.blocked = hit_ff & row_data_ff[col_ff];

endmodule

// ----- hw/rtl/losv_isqrt.sv -----
// Bit-serial integer square root of the visibility unit, one result bit per
// cycle, giving the floor of the root. Depends on losv_pkg.
module losv_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [losv_pkg::RAD_W-1:0]     radicand,
   output logic                           done,
   output logic [losv_pkg::ROOT_W-1:0]    root
);
   import losv_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [RAD_W-1:0]   rad_ff,  rad_in;
   logic [REM_W-1:0]   rem_ff,  rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;

   logic [REM_W-1:0]   rem_shift, trial;

   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + 1'b1;
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- hw/rtl/line_of_sight_visibility_unit.sv -----
// Top level of the line-of-sight visibility unit: command sequencer, distance
// falloff arithmetic and line walk. Depends on losv_pkg, losv_map, losv_isqrt.
//
// A transaction is taken when start is high and busy is low. A map write
// transaction keeps busy high through the decode state and the map write-back
// and returns nothing. A query returns exactly one result on rsp_data, marked
// by rsp_strobe for a single cycle, after its square root and line walk. The
// square root resolves one bit per cycle, and each walk step is a map row read
// followed by a check of the registered row. The walk ends at the first blocked
// tile or at the target, so it takes at most 64 steps. The receiver cannot
// stall, so results must be captured when the strobe is high. After reset busy
// stays high while the map is cleared one row per cycle; register writes are
// taken at any time.
module line_of_sight_visibility_unit #(
   parameter int MAP_WIDTH  = 64,
   parameter int MAP_HEIGHT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  losv_pkg::req_payload_type           req_data,
   output logic                                rsp_strobe,
   output losv_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_we,
   input  logic [losv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [losv_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import losv_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECODE = 9'b000000010,
      S_SQUARE = 9'b000000100,
      S_RSTART = 9'b000001000,
      S_RWAIT  = 9'b000010000,
      S_LOSS   = 9'b000100000,
      S_VIS    = 9'b001000000,
      S_WREAD  = 9'b010000000,
      S_WCHECK = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   req_payload_type      item_ff, item_in;
   logic [9:0]           offset_ff, offset_in;
   logic [7:0]           slope_ff, slope_in;
   logic signed [10:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [COORD_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic [COORD_W-1:0]   adx_ff, adx_in, ady_ff, ady_in;
   logic                 sx_ff, sx_in, sy_ff, sy_in;
   logic signed [9:0]    err_ff, err_in;
   logic [20:0]          sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [22:0]          prod_ff, prod_in;
   logic [8:0]           vis_ff, vis_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   map_req_type          map_req;
   map_rsp_type          map_rsp;
   logic                 root_start, root_done;
   logic [ROOT_W-1:0]    root;
   logic [RAD_W-1:0]     radicand;

   logic [COORD_W-1:0]   tx, ty, cx_step, cy_step;
   logic [10:0]          vx_round, vy_round;
   logic signed [21:0]   sqx_full, sqy_full;
   logic [21:0]          sq_sum;
   logic [23:0]          loss_sum;
   logic signed [17:0]   vis_diff;
   logic [8:0]           vis_clamp;
   logic signed [10:0]   e2, bdx, bdy;
   logic signed [9:0]    adx_s, ady_s, err_step;
   logic                 step_x, step_y, at_target, step_at_target;

   assign tx       = {1'b0, item_ff.cell_x};
   assign ty       = {1'b0, item_ff.cell_y};
   assign vx_round = {1'b0, item_ff.viewer_x} + 11'd8;
   assign vy_round = {1'b0, item_ff.viewer_y} + 11'd8;
   assign sqx_full = 22'(dx_ff) * 22'(dx_ff);
   assign sqy_full = 22'(dy_ff) * 22'(dy_ff);
   assign sq_sum   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign radicand = {sq_sum, 8'd0};
   assign loss_sum = {1'b0, prod_ff} + 24'd128;
   assign vis_diff = $signed({8'd0, offset_ff}) - $signed({2'd0, loss_sum[23:8]});

   always_comb begin
      if (vis_diff < 0) begin
         vis_clamp = 9'd0;
      end else if (vis_diff > 18'sd256) begin
         vis_clamp = 9'd256;
      end else begin
         vis_clamp = vis_diff[8:0];
      end
   end

   assign adx_s    = {3'd0, adx_ff};
   assign ady_s    = {3'd0, ady_ff};
   assign e2       = {err_ff, 1'b0};
   assign bdx      = {4'd0, adx_ff};
   assign bdy      = -$signed({4'd0, ady_ff});
   assign step_x   = e2 > bdy;
   assign step_y   = e2 < bdx;
   assign err_step = err_ff - (step_x ? ady_s : 10'sd0) + (step_y ? adx_s : 10'sd0);
   assign cx_step  = step_x ? (sx_ff ? cx_ff + 1'b1 : cx_ff - 1'b1) : cx_ff;
   assign cy_step  = step_y ? (sy_ff ? cy_ff + 1'b1 : cy_ff - 1'b1) : cy_ff;
   assign at_target      = (cx_ff == tx) && (cy_ff == ty);
   assign step_at_target = (cx_step == tx) && (cy_step == ty);

   always_comb begin
      offset_in = offset_ff;
      slope_in  = slope_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FALLOFF_OFFSET: offset_in = csr_wdata;
            CSR_FALLOFF_SLOPE:  slope_in  = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      adx_in        = adx_ff;
      ady_in        = ady_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      err_in        = err_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      prod_in       = prod_ff;
      vis_in        = vis_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      root_start    = 1'b0;
      map_req       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               item_in  = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (item_ff.command == CMD_WRITE) begin
               map_req.wr   = 1'b1;
               map_req.col  = tx;
               map_req.row  = ty;
               map_req.free = item_ff.cell_free;
               state_in     = S_IDLE;
            end else begin
               dx_in    = $signed({1'b0, item_ff.cell_x, 4'd0}) -
                          $signed({1'b0, item_ff.viewer_x});
               dy_in    = $signed({1'b0, item_ff.cell_y, 4'd0}) -
                          $signed({1'b0, item_ff.viewer_y});
               cx_in    = vx_round[10:4];
               cy_in    = vy_round[10:4];
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            sqx_in   = sqx_full[20:0];
            sqy_in   = sqy_full[20:0];
            adx_in   = (tx > cx_ff) ? tx - cx_ff : cx_ff - tx;
            ady_in   = (ty > cy_ff) ? ty - cy_ff : cy_ff - ty;
            sx_in    = cx_ff < tx;
            sy_in    = cy_ff < ty;
            state_in = S_RSTART;
         end
         S_RSTART: begin
            err_in     = adx_s - ady_s;
            root_start = 1'b1;
            state_in   = S_RWAIT;
         end
         S_RWAIT: begin
            if (root_done) begin
               state_in = S_LOSS;
            end
         end
         S_LOSS: begin
            prod_in  = 23'(slope_ff) * 23'(root);
            state_in = S_VIS;
         end
         S_VIS: begin
            vis_in = vis_clamp;
            if (vis_clamp == 9'd0 || at_target) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.visibility = vis_clamp;
               rsp_data_in.blocked    = 1'b0;
               state_in               = S_IDLE;
            end else begin
               state_in = S_WREAD;
            end
         end
         S_WREAD: begin
            map_req.rd  = 1'b1;
            map_req.col = cx_ff;
            map_req.row = cy_ff;
            state_in    = S_WCHECK;
         end
         S_WCHECK: begin
            if (map_rsp.blocked) begin
               rsp_strobe_in          = 1'b1;
               rsp_data_in.visibility = 9'd0;
               rsp_data_in.blocked    = 1'b1;
               state_in               = S_IDLE;
            end else begin
               cx_in  = cx_step;
               cy_in  = cy_step;
               err_in = err_step;
               if (step_at_target) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_data_in.visibility = vis_ff;
                  rsp_data_in.blocked    = 1'b0;
                  state_in               = S_IDLE;
               end else begin
                  state_in = S_WREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         offset_ff     <= OFFSET_RESET;
         slope_ff      <= SLOPE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         offset_ff     <= offset_in;
         slope_ff      <= slope_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      err_ff      <= err_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      prod_ff     <= prod_in;
      vis_ff      <= vis_in;
      rsp_data_ff <= rsp_data_in;
   end

   losv_map #(
      .MAP_WIDTH  (MAP_WIDTH),
      .MAP_HEIGHT (MAP_HEIGHT)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .req   (map_req),
      .rsp   (map_rsp)
   );

   losv_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   assign busy       = (state_ff != S_IDLE) | map_rsp.busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // A result is only ever produced by the last stages of a query.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == S_VIS || $past(state_ff) == S_WCHECK))
      else $error("result strobe without a finishing query");

   // A transaction that was blocked on the line always reports zero visibility.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.blocked |-> rsp_data.visibility == 9'd0)
      else $error("blocked result with nonzero visibility");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.visibility <= 9'd256)
      else $error("visibility above full scale");

   // Map reads must never overlap a clearing pass or a pending write-back.
   assert property (@(posedge clock) disable iff (reset)
      map_req.rd |-> !map_rsp.busy)
      else $error("map read while the map is busy");

   // The square root finishes only while the sequencer is waiting for it.
   assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == S_RWAIT)
      else $error("square root completed outside its wait state");

endmodule

// ----- dv/losv_checker.sv -----
`timescale 1ns / 1ps
// Checker for the line-of-sight visibility unit: watches the request, result and
// register channels, predicts each query result and compares it field by field.
// Depends on losv_pkg only.
module losv_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  losv_pkg::req_payload_type           req_data,
   input  logic                                rsp_strobe,
   input  losv_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_we,
   input  logic [losv_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [losv_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   import losv_pkg::*;

   localparam int GRID_COLS  = 64;
   localparam int GRID_ROWS  = 64;
   localparam int STEP_BOUND = 256;

   bit              blocked_tiles [GRID_ROWS][GRID_COLS];
   logic [9:0]      offset_q8 = OFFSET_RESET;
   logic [7:0]      slope_q8  = SLOPE_RESET;
   rsp_payload_type visibility_expected_q[$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic bit tile_blocks(input int col, input int row);
      if (col < 0 || row < 0 || col >= GRID_COLS || row >= GRID_ROWS) begin
         return 1'b0;
      end
      return blocked_tiles[row][col];
   endfunction

   function automatic rsp_payload_type predict_visibility(input req_payload_type item);
      longint          dx;
      longint          dy;
      longint          radicand;
      longint          root;
      longint          trial;
      int              loss;
      int              vis;
      int              cx;
      int              cy;
      int              tx;
      int              ty;
      int              adx;
      int              ady;
      int              sx;
      int              sy;
      int              err;
      int              e2;
      int              steps;
      bit              hit;
      rsp_payload_type outcome;
      tx = int'(item.cell_x);
      ty = int'(item.cell_y);
      dx = longint'(tx * 16) - longint'(item.viewer_x);
      dy = longint'(ty * 16) - longint'(item.viewer_y);
      radicand = (dx * dx + dy * dy) << 8;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (64'sd1 << b);
         if (trial * trial <= radicand) begin
            root = trial;
         end
      end
      loss = (int'(slope_q8) * int'(root) + 128) >>> 8;
      vis  = int'(offset_q8) - loss;
      if (vis < 0) begin
         vis = 0;
      end
      if (vis > 256) begin
         vis = 256;
      end
      hit = 1'b0;
      cx  = (int'(item.viewer_x) + 8) >>> 4;
      cy  = (int'(item.viewer_y) + 8) >>> 4;
      adx = (tx > cx) ? tx - cx : cx - tx;
      ady = (ty > cy) ? ty - cy : cy - ty;
      sx  = (cx < tx) ? 1 : -1;
      sy  = (cy < ty) ? 1 : -1;
      err = adx - ady;
      for (steps = 0; steps < STEP_BOUND && vis > 0 && !(cx == tx && cy == ty); steps++) begin
         if (tile_blocks(cx, cy)) begin
            vis = 0;
            hit = 1'b1;
         end
         e2 = 2 * err;
         if (e2 > -ady) begin
            err += -ady;
            cx  += sx;
         end
         if (e2 < adx) begin
            err += adx;
            cy  += sy;
         end
      end
      outcome.visibility = 9'(vis);
      outcome.blocked    = hit;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type wanted;
      if (reset) begin
         foreach (blocked_tiles[r, c]) begin
            blocked_tiles[r][c] = 1'b0;
         end
         offset_q8 = OFFSET_RESET;
         slope_q8  = SLOPE_RESET;
         visibility_expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FALLOFF_OFFSET: offset_q8 = csr_wdata;
               CSR_FALLOFF_SLOPE:  slope_q8  = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (visibility_expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result visibility=%0d blocked=%0d",
                                         rsp_data.visibility, rsp_data.blocked));
            end else begin
               wanted = visibility_expected_q.pop_front();
               if (rsp_data.visibility !== wanted.visibility) begin
                  report_mismatch($sformatf("visibility %0d, expected %0d",
                                            rsp_data.visibility, wanted.visibility));
               end
               if (rsp_data.blocked !== wanted.blocked) begin
                  report_mismatch($sformatf("blocked %0d, expected %0d",
                                            rsp_data.blocked, wanted.blocked));
               end
            end
         end
         if (start && !busy) begin
            if (req_data.command == CMD_WRITE) begin
               blocked_tiles[req_data.cell_y][req_data.cell_x] = !req_data.cell_free;
            end else begin
               visibility_expected_q.push_back(predict_visibility(req_data));
            end
         end
      end
      pending_count = visibility_expected_q.size();
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the line-of-sight visibility unit testbench: clock, reset, directed and
// random map writes and queries, register phases and the verdict.
// Depends on losv_pkg, losv_checker and line_of_sight_visibility_unit.
module tb_top;
   import losv_pkg::*;

   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 270;
   localparam int CYCLE_LIMIT     = 1200000;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   req_payload_type        req_data  = '0;
   logic                   rsp_strobe;
   rsp_payload_type        rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_FALLOFF_OFFSET;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     mismatch_count;
   int                     pending_count;
   int                     cycle_count = 0;

   line_of_sight_visibility_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   losv_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int clamp_tile(input int v);
      return (v < 0) ? 0 : (v > 63) ? 63 : v;
   endfunction

   function automatic req_payload_type make_write(input int col, input int row, input bit free);
      req_payload_type item;
      item           = req_payload_type'({$urandom, $urandom});
      item.command   = CMD_WRITE;
      item.cell_x    = 6'(col);
      item.cell_y    = 6'(row);
      item.cell_free = free;
      return item;
   endfunction

   function automatic req_payload_type make_query(input int col, input int row,
                                                  input int vx, input int vy);
      req_payload_type item;
      item          = req_payload_type'({$urandom, $urandom});
      item.command  = CMD_QUERY;
      item.cell_x   = 6'(col);
      item.cell_y   = 6'(row);
      item.viewer_x = 10'(vx);
      item.viewer_y = 10'(vy);
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with start still high.
   task automatic drive_transaction(input req_payload_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   initial begin
      int  phase_offset [PHASES];
      int  phase_slope  [PHASES];
      int  offset_value;
      int  slope_value;
      int  last_col;
      int  last_row;
      int  vtx;
      int  vty;
      bit  idling_on;
      req_payload_type item;

      phase_offset = '{512, 1023, 0, 300, 256, -1, 512};
      phase_slope  = '{77, 0, 255, 20, 255, -1, 77};
      last_col     = 0;
      last_row     = 0;
      idling_on    = 1'b0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      drive_transaction(make_query(0, 0, 0, 0));
      drive_transaction(make_write(1, 1, 1'b0));
      drive_transaction(make_query(3, 3, 0, 0));
      drive_transaction(make_query(0, 0, 16, 16));
      drive_transaction(make_query(1, 1, 0, 0));
      drive_transaction(make_write(1, 1, 1'b1));
      drive_transaction(make_query(3, 3, 0, 0));
      drive_transaction(make_query(63, 63, 0, 0));
      drive_transaction(make_write(63, 63, 1'b0));
      drive_transaction(make_query(60, 60, 1023, 1023));
      drive_transaction(make_query(63, 0, 1023, 0));
      drive_transaction(make_write(0, 63, 1'b0));
      drive_transaction(make_query(0, 60, 0, 1000));
      drive_transaction(make_write(63, 0, 1'b0));
      drive_transaction(make_query(60, 2, 1023, 8));
      drive_transaction(make_query(10, 3, 87, 152));
      drive_transaction(make_query(2, 9, 40, 40));
      drive_transaction(make_write(4, 4, 1'b0));
      drive_transaction(make_query(8, 8, 0, 0));
      drive_transaction(make_query(0, 0, 127, 127));
      drive_transaction(make_write(4, 4, 1'b1));
      drive_transaction(make_query(8, 8, 0, 0));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            offset_value = (phase_offset[phase] < 0) ? $urandom_range(0, 1023)
                                                     : phase_offset[phase];
            slope_value  = (phase_slope[phase] < 0) ? $urandom_range(0, 255)
                                                    : phase_slope[phase];
            csr_we    <= 1'b1;
            csr_index <= CSR_FALLOFF_OFFSET;
            csr_wdata <= 10'(offset_value);
            @(negedge clock);
            csr_index <= CSR_FALLOFF_SLOPE;
            csr_wdata <= {2'($urandom_range(0, 3)), 8'(slope_value)};
            @(negedge clock);
            csr_we <= 1'b0;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) begin
               idling_on = (phase != PHASES - 1) && ($urandom_range(0, 4) < 3);
            end
            if (idling_on && $urandom_range(0, 3) == 0) begin
               start    <= 1'b0;
               req_data <= req_payload_type'({$urandom, $urandom});
               repeat ($urandom_range(1, 10)) @(negedge clock);
            end
            if ($urandom_range(0, 9) < 3) begin
               if ($urandom_range(0, 4) == 0) begin
                  item = make_write($urandom_range(0, 63), $urandom_range(0, 63),
                                    $urandom_range(0, 99) < 55);
               end else begin
                  item = make_write(clamp_tile(last_col + $urandom_range(0, 12) - 6),
                                    clamp_tile(last_row + $urandom_range(0, 12) - 6),
                                    $urandom_range(0, 99) < 55);
               end
            end else begin
               vtx = $urandom_range(0, 63);
               vty = $urandom_range(0, 63);
               if ($urandom_range(0, 9) < 7) begin
                  item = make_query(clamp_tile(vtx + $urandom_range(0, 16) - 8),
                                    clamp_tile(vty + $urandom_range(0, 16) - 8),
                                    vtx * 16 + $urandom_range(0, 15),
                                    vty * 16 + $urandom_range(0, 15));
               end else begin
                  item = make_query($urandom_range(0, 63), $urandom_range(0, 63),
                                    $urandom_range(0, 1023), $urandom_range(0, 1023));
               end
               last_col = vtx;
               last_row = vty;
            end
            drive_transaction(item);
         end
      end

      wait_drained();
      repeat (40) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
